@@ rtl/core/srr_pkg.sv @@
// ----------------------------------------------------------------------------
// srr_pkg: shared types and constants of the SpO2 ratio-of-ratios estimator
// Sample, result and job formats, fixed-point constants, back-end states.
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int SAMPLE_BITS = 18;
    localparam int TOTAL_BITS  = 25;
    localparam int PROD_BITS   = SAMPLE_BITS + TOTAL_BITS;
    localparam int QUOT_BITS   = 15;
    localparam int SLOPE_BITS  = 13;
    localparam int NUM_BITS    = PROD_BITS + SLOPE_BITS;
    localparam int EST_BITS    = 15;
    localparam int CNT_BITS    = $clog2(QUOT_BITS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SLOPE_BITS-1:0] SLOPE_SCALED = SLOPE_BITS'(6400);
    localparam logic [QUOT_BITS:0]    BASE_SCALED  = (QUOT_BITS + 1)'(28160);
    localparam logic [QUOT_BITS:0]    TOP_SCALED   = (QUOT_BITS + 1)'(25600);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] ir_sample;
        logic [SAMPLE_BITS-1:0] red_sample;
        logic                   last_sample;
    } t_sample;

    typedef struct packed {
        logic [EST_BITS-1:0] spo2_estimate;
        logic                spo2_valid;
    } t_result;

    typedef struct packed {
        logic                   valid;
        logic [SAMPLE_BITS-1:0] ir_ac;
        logic [SAMPLE_BITS-1:0] red_ac;
        logic [TOTAL_BITS-1:0]  ir_total;
        logic [TOTAL_BITS-1:0]  red_total;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SCALE,
        BK_CHECK,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

@@ rtl/core/srr_front.sv @@
// ----------------------------------------------------------------------------
// srr_front: per-buffer statistics
// Tracks min, max and saturating sum of both channels; on the last sample
// of a buffer it emits one job to the back end and re-arms.
// ----------------------------------------------------------------------------
module srr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  srr_pkg::t_sample i_item,
    input  logic            i_job_full,
    output logic            o_full,
    output logic            o_job_push,
    output srr_pkg::t_job   o_job
);
    import srr_pkg::*;

    logic                   r_start;
    logic [SAMPLE_BITS-1:0] r_ir_lo, r_ir_hi, r_red_lo, r_red_hi;
    logic [TOTAL_BITS-1:0]  r_ir_tot, r_red_tot;

    logic [SAMPLE_BITS-1:0] n_ir_lo, n_ir_hi, n_red_lo, n_red_hi;
    logic [TOTAL_BITS-1:0]  n_ir_tot, n_red_tot;
    logic [TOTAL_BITS:0]    w_ir_sum, w_red_sum;
    logic                   w_accept;

    assign o_full   = i_job_full;
    assign w_accept = i_push && !i_job_full;

    always_comb begin
        if (r_start) begin
            n_ir_lo  = i_item.ir_sample;
            n_ir_hi  = i_item.ir_sample;
            n_red_lo = i_item.red_sample;
            n_red_hi = i_item.red_sample;
            w_ir_sum  = (TOTAL_BITS + 1)'(i_item.ir_sample);
            w_red_sum = (TOTAL_BITS + 1)'(i_item.red_sample);
        end else begin
            n_ir_lo  = (i_item.ir_sample < r_ir_lo) ? i_item.ir_sample : r_ir_lo;
            n_ir_hi  = (i_item.ir_sample > r_ir_hi) ? i_item.ir_sample : r_ir_hi;
            n_red_lo = (i_item.red_sample < r_red_lo) ? i_item.red_sample : r_red_lo;
            n_red_hi = (i_item.red_sample > r_red_hi) ? i_item.red_sample : r_red_hi;
            w_ir_sum  = {1'b0, r_ir_tot} + (TOTAL_BITS + 1)'(i_item.ir_sample);
            w_red_sum = {1'b0, r_red_tot} + (TOTAL_BITS + 1)'(i_item.red_sample);
        end
        n_ir_tot  = w_ir_sum[TOTAL_BITS] ? '1 : w_ir_sum[TOTAL_BITS-1:0];
        n_red_tot = w_red_sum[TOTAL_BITS] ? '1 : w_red_sum[TOTAL_BITS-1:0];
    end

    always_comb begin
        o_job.ir_ac     = n_ir_hi - n_ir_lo;
        o_job.red_ac    = n_red_hi - n_red_lo;
        o_job.ir_total  = n_ir_tot;
        o_job.red_total = n_red_tot;
        o_job.valid     = (n_ir_tot != '0) && (n_red_tot != '0) &&
                          (o_job.ir_ac != '0) && (o_job.red_ac != '0);
        o_job_push      = w_accept && i_item.last_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
        end else if (w_accept) begin
            r_start <= i_item.last_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ir_lo   <= n_ir_lo;
            r_ir_hi   <= n_ir_hi;
            r_red_lo  <= n_red_lo;
            r_red_hi  <= n_red_hi;
            r_ir_tot  <= n_ir_tot;
            r_red_tot <= n_red_tot;
        end
    end

endmodule

@@ rtl/core/srr_job_queue.sv @@
// ----------------------------------------------------------------------------
// srr_job_queue: short job queue
// Decouples the statistics front end from the ratio back end.
// ----------------------------------------------------------------------------
module srr_job_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  srr_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output srr_pkg::t_job o_job
);
    import srr_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

    t_job                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("job queue count beyond depth");

    a_no_blind_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job popped from empty queue");

endmodule

@@ rtl/core/srr_back.sv @@
// ----------------------------------------------------------------------------
// srr_back: ratio-of-ratios evaluation
// Forms both cross products, scales, divides by restoring steps and maps
// the rounded-up ratio to the clamped estimate in an output register.
// ----------------------------------------------------------------------------
module srr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  srr_pkg::t_job    i_job,
    output logic             o_job_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output srr_pkg::t_result o_result
);
    import srr_pkg::*;

    t_back_state           r_state, n_state;
    t_job                  r_job;
    logic [PROD_BITS-1:0]  r_a, r_den, r_rem;
    logic [QUOT_BITS-1:0]  r_q;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_ovf;
    logic                  r_out_full;
    t_result               r_out;

    logic                  w_load;
    logic [NUM_BITS-1:0]   w_num;
    logic [PROD_BITS:0]    w_shift;
    logic                  w_ge;
    logic [QUOT_BITS:0]    w_ceil;
    logic [QUOT_BITS:0]    w_diff;
    t_result               w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        w_load    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state   = i_job.valid ? BK_MUL : BK_DONE;
                end
            end
            BK_MUL:   n_state = BK_SCALE;
            BK_SCALE: n_state = BK_CHECK;
            BK_CHECK: n_state = BK_DIV;
            BK_DIV: begin
                if (r_cnt == CNT_BITS'(QUOT_BITS - 1)) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!r_out_full || i_pop) begin
                    w_load  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign w_num   = NUM_BITS'(r_a) * NUM_BITS'(SLOPE_SCALED);
    assign w_shift = {r_rem, r_q[QUOT_BITS-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_comb begin
        w_ceil = {1'b0, r_q} + (QUOT_BITS + 1)'(r_rem != '0);
        w_diff = BASE_SCALED - w_ceil;
        w_result.spo2_valid = r_job.valid;
        if (!r_job.valid || r_ovf || (w_ceil >= BASE_SCALED)) begin
            w_result.spo2_estimate = '0;
        end else if (w_diff > TOP_SCALED) begin
            w_result.spo2_estimate = EST_BITS'(TOP_SCALED);
        end else begin
            w_result.spo2_estimate = EST_BITS'(w_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    r_job <= i_job;
                end
            end
            BK_MUL: begin
                r_a   <= PROD_BITS'(r_job.red_ac) * PROD_BITS'(r_job.ir_total);
                r_den <= PROD_BITS'(r_job.ir_ac) * PROD_BITS'(r_job.red_total);
            end
            BK_SCALE: begin
                r_rem <= PROD_BITS'(w_num[NUM_BITS-1:QUOT_BITS]);
                r_q   <= w_num[QUOT_BITS-1:0];
            end
            BK_CHECK: begin
                r_ovf <= (r_rem >= r_den);
                r_cnt <= '0;
            end
            BK_DIV: begin
                r_rem <= w_ge ? PROD_BITS'(w_shift - {1'b0, r_den}) : PROD_BITS'(w_shift);
                r_q   <= {r_q[QUOT_BITS-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_full <= 1'b0;
        end else if (w_load) begin
            r_out_full <= 1'b1;
        end else if (i_pop) begin
            r_out_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_empty  = !r_out_full;
    assign o_result = r_out;

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_full && !r_out.spo2_valid) |-> (r_out.spo2_estimate == '0))
        else $error("invalid result carries a nonzero estimate");

    a_estimate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_full |-> ((QUOT_BITS + 1)'(r_out.spo2_estimate) <= TOP_SCALED))
        else $error("estimate above clamp");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_state == BK_IDLE && i_job_valid))
        else $error("job taken while busy");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_full && !i_pop) |=> (r_out_full && $stable(r_out)))
        else $error("waiting result overwritten");

endmodule

@@ rtl/core/spo2_ratio_of_ratios_estimator.sv @@
// ----------------------------------------------------------------------------
// spo2_ratio_of_ratios_estimator: SpO2 estimate from paired optical samples
// Statistics front end, two-entry job queue, ratio back end with divider.
//
//   channel   handshake         payload
//   samples   i_push / o_full   i_item   (ir, red, last marker)
//   results   o_empty / i_pop   o_result (estimate, valid)
//
// A sample transaction is taken every cycle while the job queue has room.
// A buffer result passes the job queue and the back end: a zero-swing buffer
// goes straight to the output register, while a valid one is multiplied,
// scaled, overflow-checked, divided in 15 restoring steps and then mapped.
// Reset is synchronous; it clears control state only, no clearing pass.
// A held result stalls the back end, then the queue, then o_full rises.
// ----------------------------------------------------------------------------
module spo2_ratio_of_ratios_estimator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  srr_pkg::t_sample i_item,
    output logic             o_empty,
    input  logic             i_pop,
    output srr_pkg::t_result o_result
);
    import srr_pkg::*;

    logic w_job_push, w_job_full, w_job_valid, w_job_pop;
    t_job w_job_in, w_job_out;

    srr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .i_job_full (w_job_full),
        .o_full     (o_full),
        .o_job_push (w_job_push),
        .o_job      (w_job_in)
    );

    srr_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .i_pop   (w_job_pop),
        .o_full  (w_job_full),
        .o_valid (w_job_valid),
        .o_job   (w_job_out)
    );

    srr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (o_result)
    );

endmodule

@@ test/spo2_ratio_of_ratios_estimator_tb.sv @@
// ----------------------------------------------------------------------------
// spo2_ratio_of_ratios_estimator_tb: self-checking bench of the SpO2 estimator
// Sends buffers of infrared/red sample pairs through the push/full side and
// checks each estimate against a bit-exact ratio-of-ratios predictor: single
// pairs, flat or zero channels, both clamps, saturating sums, random buffers,
// random noise and a long receiver hold that fills the block.
// ----------------------------------------------------------------------------
module spo2_ratio_of_ratios_estimator_tb;

    import srr_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_CAP = '1;
    localparam longint unsigned BASE_Q8  = 28160;
    localparam longint unsigned SLOPE_Q8 = 6400;
    localparam longint unsigned TOP_Q8   = 25600;
    localparam int MAX_SAMPLES_HINT = 128;

    typedef enum int {
        SHAPE_SWING,
        SHAPE_FLAT_IR,
        SHAPE_FLAT_RED,
        SHAPE_ZERO_IR,
        SHAPE_NOISE,
        SHAPE_HIGH
    } t_shape;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_push;
    logic     o_full;
    t_sample  i_item;
    logic     o_empty;
    logic     i_pop;
    t_result  o_result;

    // predictor state
    logic [SAMPLE_BITS-1:0] ir_low, ir_high, red_low, red_high;
    logic [TOTAL_BITS-1:0]  ir_total, red_total;
    logic                   new_buffer;

    t_result pending_estimates[$];

    int errors;
    int cycle_count;
    int pairs_sent;
    int full_stalls;
    int buffers_checked;
    int valid_seen;
    int top_clamps;
    int zero_estimates;
    int push_gap_pct;
    int pop_stall_pct;
    int hold_request;

    spo2_ratio_of_ratios_estimator DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_item   (i_item),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [TOTAL_BITS-1:0] add_saturating(
        input logic [TOTAL_BITS-1:0] total, input logic [SAMPLE_BITS-1:0] sample);
        logic [TOTAL_BITS:0] sum;
        sum = {1'b0, total} + (TOTAL_BITS + 1)'(sample);
        return sum[TOTAL_BITS] ? TOTAL_CAP : sum[TOTAL_BITS-1:0];
    endfunction

    function automatic t_result spo2_from_stats(
        input logic [SAMPLE_BITS-1:0] ir_swing, input logic [SAMPLE_BITS-1:0] red_swing,
        input logic [TOTAL_BITS-1:0] ir_sum, input logic [TOTAL_BITS-1:0] red_sum);
        t_result         res;
        longint unsigned num, den, scaled, est;
        res = '0;
        if (ir_sum != 0 && red_sum != 0 && ir_swing != 0 && red_swing != 0) begin
            num    = longint'(red_swing) * longint'(ir_sum);
            den    = longint'(ir_swing) * longint'(red_sum);
            scaled = (SLOPE_Q8 * num + den - 1) / den;
            est    = (scaled >= BASE_Q8) ? 0 : BASE_Q8 - scaled;
            if (est > TOP_Q8)
                est = TOP_Q8;
            res.spo2_estimate = EST_BITS'(est);
            res.spo2_valid    = 1'b1;
        end
        return res;
    endfunction

    task automatic accumulate_pair(input t_sample s);
        if (new_buffer) begin
            ir_low    = s.ir_sample;
            ir_high   = s.ir_sample;
            red_low   = s.red_sample;
            red_high  = s.red_sample;
            ir_total  = add_saturating('0, s.ir_sample);
            red_total = add_saturating('0, s.red_sample);
        end else begin
            if (s.ir_sample < ir_low)
                ir_low = s.ir_sample;
            if (s.ir_sample > ir_high)
                ir_high = s.ir_sample;
            if (s.red_sample < red_low)
                red_low = s.red_sample;
            if (s.red_sample > red_high)
                red_high = s.red_sample;
            ir_total  = add_saturating(ir_total, s.ir_sample);
            red_total = add_saturating(red_total, s.red_sample);
        end
        new_buffer = s.last_sample;
        if (s.last_sample)
            pending_estimates.push_back(spo2_from_stats(ir_high - ir_low,
                red_high - red_low, ir_total, red_total));
    endtask

    // Offer one pair, hold it until the block takes it, then maybe idle.
    task automatic send_pair(input int unsigned ir, input int unsigned red, input bit last);
        t_sample s;
        s.ir_sample   = SAMPLE_BITS'(ir);
        s.red_sample  = SAMPLE_BITS'(red);
        s.last_sample = last;
        i_item <= s;
        i_push <= 1'b1;
        do begin
            @(posedge i_clk);
            if (o_full)
                full_stalls++;
        end while (o_full);
        accumulate_pair(s);
        pairs_sent++;
        if (push_gap_pct > 0 && $urandom_range(0, 99) < push_gap_pct) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic stop_push();
        i_push <= 1'b0;
    endtask

    task automatic send_buffer(input int len, input t_shape shape);
        int unsigned ir_base, ir_span, red_base, red_span, ir, red;
        ir_base  = $urandom_range(0, SAMPLE_MAX);
        red_base = $urandom_range(0, SAMPLE_MAX);
        ir_span  = $urandom_range(0, SAMPLE_MAX - ir_base) >> $urandom_range(0, 17);
        red_span = $urandom_range(0, SAMPLE_MAX - red_base) >> $urandom_range(0, 17);
        case (shape)
            SHAPE_FLAT_IR: begin
                ir_span = 0;
            end
            SHAPE_FLAT_RED: begin
                red_span = 0;
            end
            SHAPE_ZERO_IR: begin
                ir_base = 0;
                ir_span = 0;
            end
            SHAPE_HIGH: begin
                ir_base  = SAMPLE_MAX - $urandom_range(0, 4095);
                red_base = SAMPLE_MAX - $urandom_range(0, 4095);
                ir_span  = $urandom_range(0, SAMPLE_MAX - ir_base);
                red_span = $urandom_range(0, SAMPLE_MAX - red_base);
            end
            default: begin
            end
        endcase
        for (int i = 0; i < len; i++) begin
            if (shape == SHAPE_NOISE) begin
                ir  = $urandom_range(0, SAMPLE_MAX);
                red = $urandom_range(0, SAMPLE_MAX);
            end else begin
                ir  = ir_base + $urandom_range(0, ir_span);
                red = red_base + $urandom_range(0, red_span);
            end
            send_pair(ir, red, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        while (pending_estimates.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        i_pop      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (!i_rst_n) begin
                i_pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_pop <= 1'b0;
            end else if (pop_stall_pct > 0 && $urandom_range(0, 99) < pop_stall_pct) begin
                stall_left = $urandom_range(1, 6) - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && !o_empty && i_pop) begin
            if (pending_estimates.size() == 0) begin
                $display("%0t ERROR unexpected result: expected none, actual est %0d valid %0b",
                         $time, o_result.spo2_estimate, o_result.spo2_valid);
                errors++;
            end else begin
                want = pending_estimates.pop_front();
                buffers_checked++;
                if (want.spo2_valid) begin
                    valid_seen++;
                    if (want.spo2_estimate == EST_BITS'(TOP_Q8))
                        top_clamps++;
                    if (want.spo2_estimate == 0)
                        zero_estimates++;
                end
                if (o_result.spo2_estimate !== want.spo2_estimate) begin
                    $display("%0t ERROR spo2_estimate: expected %0d, actual %0d",
                             $time, want.spo2_estimate, o_result.spo2_estimate);
                    errors++;
                end
                if (o_result.spo2_valid !== want.spo2_valid) begin
                    $display("%0t ERROR spo2_valid: expected %0b, actual %0b",
                             $time, want.spo2_valid, o_result.spo2_valid);
                    errors++;
                end
            end
        end
    end

    task automatic test_single_pair();
        send_pair(5000, 7000, 1'b1);
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        stop_push();
    endtask

    task automatic test_degenerate();
        send_pair(0, 100, 1'b0);
        send_pair(0, 900, 1'b1);
        send_pair(1000, 500, 1'b0);
        send_pair(3000, 500, 1'b1);
        stop_push();
    endtask

    task automatic test_extremes();
        send_pair(0, SAMPLE_MAX, 1'b0);
        send_pair(SAMPLE_MAX, 0, 1'b1);
        send_pair(SAMPLE_MAX, 0, 1'b0);
        send_pair(0, SAMPLE_MAX, 1'b0);
        send_pair(131072, 131072, 1'b1);
        stop_push();
    endtask

    task automatic test_clamps();
        send_pair(1000, 1000, 1'b0);
        send_pair(2000, 1010, 1'b1);
        send_pair(100000, 0, 1'b0);
        send_pair(100001, SAMPLE_MAX, 1'b1);
        // ratio of exactly 4.4 and exactly 0.4
        send_pair(100, 83, 1'b0);
        send_pair(110, 127, 1'b1);
        send_pair(100, 103, 1'b0);
        send_pair(110, 107, 1'b1);
        stop_push();
    endtask

    task automatic test_random_buffers(input int pair_budget);
        int     start, len;
        t_shape shape;
        start = pairs_sent;
        while (pairs_sent - start < pair_budget) begin
            if ($urandom_range(0, 7) == 0) begin
                push_gap_pct  = 0;
                pop_stall_pct = 0;
            end else begin
                push_gap_pct  = $urandom_range(5, 30);
                pop_stall_pct = $urandom_range(5, 30);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 128)
                                              : $urandom_range(2, 12);
            case ($urandom_range(0, 19))
                0:       shape = SHAPE_FLAT_IR;
                1:       shape = SHAPE_FLAT_RED;
                2:       shape = SHAPE_ZERO_IR;
                3:       shape = SHAPE_HIGH;
                4:       shape = SHAPE_NOISE;
                default: shape = SHAPE_SWING;
            endcase
            send_buffer(len, shape);
        end
        stop_push();
    endtask

    task automatic test_noise_pairs(input int count);
        for (int i = 0; i < count; i++)
            send_pair($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                      $urandom_range(0, 1));
        if (!new_buffer)
            send_pair($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX), 1'b1);
        stop_push();
    endtask

    task automatic test_backpressure();
        push_gap_pct = 0;
        hold_request = 400;
        for (int i = 0; i < 25; i++)
            send_buffer($urandom_range(2, 3), SHAPE_SWING);
        stop_push();
    endtask

    task automatic test_saturation();
        push_gap_pct  = 10;
        pop_stall_pct = 10;
        send_buffer(MAX_SAMPLES_HINT, SHAPE_HIGH);
        send_buffer(140, SHAPE_HIGH);
        send_buffer(200, SHAPE_HIGH);
        stop_push();
    endtask

    task automatic test_steady_tail();
        push_gap_pct  = 0;
        pop_stall_pct = 0;
        for (int i = 0; i < 20; i++)
            send_buffer($urandom_range(2, 8), SHAPE_SWING);
        stop_push();
    endtask

    initial begin
        errors          = 0;
        cycle_count     = 0;
        pairs_sent      = 0;
        full_stalls     = 0;
        buffers_checked = 0;
        valid_seen      = 0;
        top_clamps      = 0;
        zero_estimates  = 0;
        push_gap_pct    = 20;
        pop_stall_pct   = 20;
        hold_request    = 0;
        new_buffer      = 1'b1;
        ir_low          = '0;
        ir_high         = '0;
        red_low         = '0;
        red_high        = '0;
        ir_total        = '0;
        red_total       = '0;
        i_rst_n         = 1'b0;
        i_push          = 1'b0;
        i_item          = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_pair();
        test_degenerate();
        test_extremes();
        test_clamps();
        test_random_buffers(550);
        test_noise_pairs(150);
        test_backpressure();
        test_saturation();
        test_steady_tail();

        wait_drained();
        $display("covered %0d sample pairs, %0d buffers checked: %0d valid, %0d at 100%%, %0d at 0",
                 pairs_sent, buffers_checked, valid_seen, top_clamps, zero_estimates);
        $display("input stalled by full for %0d cycles", full_stalls);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
